[src/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/salsa_pkg.sv]
`timescale 1ns / 1ps

package salsa_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 16;
    localparam int LANE_W     = 64;
    localparam int NUM_LANES  = 8;
    localparam int COUNT_W    = 7;
    localparam int MAX_BYTES  = 64;
    localparam int MAX_ROUNDS = 20;
    localparam int STEPS_PER_ROUND = 4;
    localparam int NUM_STEPS  = MAX_ROUNDS * STEPS_PER_ROUND;
    localparam int RND_W      = $clog2(MAX_ROUNDS + 1);
    localparam int PHASE_W    = $clog2(NUM_STEPS + 1);
    localparam int RC_W       = 5;
    localparam int KEY_REGS   = 4;
    localparam int CFG_IDX_W  = 3;

    localparam int S_TDATA_W  = 648;
    localparam int M_TDATA_W  = 520;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS    = 3'd4;

    localparam logic [RC_W-1:0] RC_RESET = RC_W'(MAX_ROUNDS);

    localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

    localparam int ROT_A = 7;
    localparam int ROT_B = 9;
    localparam int ROT_C = 13;
    localparam int ROT_D = 18;

    // Word indices (a, b, c, d) of each quarter for column and row rounds.
    localparam logic [3:0] COL_IDX [4][4] = '{
        '{4'd0,  4'd4,  4'd8,  4'd12},
        '{4'd5,  4'd9,  4'd13, 4'd1},
        '{4'd10, 4'd14, 4'd2,  4'd6},
        '{4'd15, 4'd3,  4'd7,  4'd11}
    };
    localparam logic [3:0] ROW_IDX [4][4] = '{
        '{4'd0,  4'd1,  4'd2,  4'd3},
        '{4'd5,  4'd6,  4'd7,  4'd4},
        '{4'd10, 4'd11, 4'd8,  4'd9},
        '{4'd15, 4'd12, 4'd13, 4'd14}
    };

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

    typedef struct packed {
        logic [KEY_REGS-1:0][LANE_W-1:0] key;
    } key_t;

    typedef struct packed {
        state_t                          work;
        logic [LANE_W-1:0]               nonce;
        logic [LANE_W-1:0]               ctr;
        logic [NUM_LANES-1:0][LANE_W-1:0] data;
        logic [COUNT_W-1:0]              count;
        logic [RND_W-1:0]                rounds;
        logic [PHASE_W-1:0]              phase;
    } stage_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][LANE_W-1:0] cipher;
        logic [COUNT_W-1:0]              count;
    } result_t;

    function automatic state_t build_init(key_t k, logic [LANE_W-1:0] nonce,
                                          logic [LANE_W-1:0] ctr);
        state_t s;
        s[0]  = SIGMA0;
        s[1]  = k.key[0][31:0];
        s[2]  = k.key[0][63:32];
        s[3]  = k.key[1][31:0];
        s[4]  = k.key[1][63:32];
        s[5]  = SIGMA1;
        s[6]  = nonce[31:0];
        s[7]  = nonce[63:32];
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        s[10] = SIGMA2;
        s[11] = k.key[2][31:0];
        s[12] = k.key[2][63:32];
        s[13] = k.key[3][31:0];
        s[14] = k.key[3][63:32];
        s[15] = SIGMA3;
        return s;
    endfunction

    function automatic logic [3:0] quarter_idx(logic col, logic [1:0] q, logic [1:0] pos);
        return col ? COL_IDX[q][pos] : ROW_IDX[q][pos];
    endfunction

    function automatic logic [WORD_W-1:0] rot_step(logic [WORD_W-1:0] v, logic [1:0] j);
        logic [WORD_W-1:0] r;
        case (j)
            2'd0:    r = (v << ROT_A) | (v >> (WORD_W - ROT_A));
            2'd1:    r = (v << ROT_B) | (v >> (WORD_W - ROT_B));
            2'd2:    r = (v << ROT_C) | (v >> (WORD_W - ROT_C));
            default: r = (v << ROT_D) | (v >> (WORD_W - ROT_D));
        endcase
        return r;
    endfunction

endpackage

[src/salsa_step_cell.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module salsa_step_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  salsa_pkg::stage_t in_pl,
    output logic              out_valid,
    input  logic              out_ready,
    output salsa_pkg::stage_t out_pl
);
    import salsa_pkg::*;

    logic   vld_reg;
    stage_t pl_reg;
    stage_t pl_next;
    logic   load;
    logic   active;
    logic   col;
    logic [1:0] j;
    logic [1:0] j_tgt;
    logic [1:0] j_prev;

    assign in_ready  = !vld_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_pl    = pl_reg;

    // Phase counts quarter-round steps; bits above the low two give the round.
    assign j      = in_pl.phase[1:0];
    assign j_tgt  = j + 2'd1;
    assign j_prev = j + 2'd3;
    assign col    = !in_pl.phase[2];
    assign active = in_pl.phase[PHASE_W-1:2] < in_pl.rounds;

    always_comb
    begin
        pl_next       = in_pl;
        pl_next.phase = in_pl.phase + 1'b1;
        if (active)
        begin
            // The four quarters touch disjoint words: update them side by side.
            for (int q = 0; q < 4; q++)
            begin
                pl_next.work[quarter_idx(col, 2'(q), j_tgt)] =
                    in_pl.work[quarter_idx(col, 2'(q), j_tgt)] ^
                    rot_step(in_pl.work[quarter_idx(col, 2'(q), j)] +
                             in_pl.work[quarter_idx(col, 2'(q), j_prev)], j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pl_reg <= pl_next;
    end

    `ASSERT_NEXT(a_phase_adv, load, vld_reg && (pl_reg.phase == PHASE_W'($past(in_pl.phase) + 1'b1)), "step cell phase did not advance")
    `ASSERT_NEXT(a_hold_word, vld_reg && !out_ready, vld_reg && $stable(pl_reg), "step cell dropped a stalled word")

endmodule

[src/salsa_out_cell.sv]
`timescale 1ns / 1ps

module salsa_out_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  salsa_pkg::key_t    key,
    input  logic               in_valid,
    output logic               in_ready,
    input  salsa_pkg::stage_t  in_pl,
    output logic               out_valid,
    input  logic               out_ready,
    output salsa_pkg::result_t out_res
);
    import salsa_pkg::*;

    logic    vld_reg;
    result_t res_reg;
    result_t res_next;
    state_t  init;
    state_t  ks;
    logic    load;

    assign in_ready  = !vld_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    assign init = build_init(key, in_pl.nonce, in_pl.ctr);

    always_comb
    begin
        for (int w = 0; w < NUM_WORDS; w++)
            ks[w] = in_pl.work[w] + init[w];
        res_next.count = in_pl.count;
        for (int k = 0; k < NUM_LANES; k++)
            res_next.cipher[k] = in_pl.data[k] ^ {ks[2*k+1], ks[2*k]};
        // Zero every byte at or past the count.
        for (int b = 0; b < MAX_BYTES; b++)
        begin
            if (COUNT_W'(b) >= in_pl.count)
                res_next.cipher[b/8][(b%8)*8 +: 8] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

endmodule

[src/salsa20_stream_cipher_block_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Salsa20 block cipher core: each input word is one 64-byte block (nonce, block counter, eight
// little-endian data lanes, byte count) and each output word is the data XOR keystream with bytes
// at or past the count forced to zero. The core is a chain of 80 step cells, one quarter-round
// step (add, rotate, XOR on all four quarters) per cell, followed by one output cell that adds
// the initial state and masks the data; cells beyond the configured round count pass the state
// through unchanged. Each block is registered in every step cell in turn and then in the output
// cell before it reaches m_tdata, and the chain takes one block per cycle for as long as the
// output side keeps taking results; each cell holds its word under backpressure and accepts a
// new one whenever it is empty or draining. Key and round count registers may only be written
// while the chain is empty; round counts above 20 run 20 rounds, byte counts above 64 are
// treated as 64. The config port is always ready.
module salsa20_stream_cipher_block_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // nonce[63:0], block_counter[127:64], data_word_0..7[639:128], byte_count[646:640], pad
    input  logic [salsa_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // cipher_word_0..7[511:0], valid_bytes[518:512], pad
    output logic [salsa_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [salsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [salsa_pkg::LANE_W-1:0]          cfg_data
);
    import salsa_pkg::*;

    localparam int CNT_LO = NUM_LANES * LANE_W;

    key_t              key_reg;
    logic [RC_W-1:0]   rounds_reg;
    logic [LANE_W-1:0] in_nonce;
    logic [LANE_W-1:0] in_ctr;
    logic [COUNT_W-1:0] in_count;
    stage_t            entry_pl;
    result_t           res;

    stage_t link_pl    [NUM_STEPS+1];
    logic   link_valid [NUM_STEPS+1];
    logic   link_ready [NUM_STEPS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= RC_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY_0_7:   key_reg.key[0] <= cfg_data;
                REG_KEY_8_15:  key_reg.key[1] <= cfg_data;
                REG_KEY_16_23: key_reg.key[2] <= cfg_data;
                REG_KEY_24_31: key_reg.key[3] <= cfg_data;
                REG_ROUNDS:    rounds_reg     <= cfg_data[RC_W-1:0];
                default:       ;
            endcase
        end
    end

    assign in_nonce = s_tdata[LANE_W-1:0];
    assign in_ctr   = s_tdata[2*LANE_W-1:LANE_W];
    assign in_count = s_tdata[2*LANE_W+CNT_LO +: COUNT_W];

    always_comb
    begin
        entry_pl.nonce = in_nonce;
        entry_pl.ctr   = in_ctr;
        for (int k = 0; k < NUM_LANES; k++)
            entry_pl.data[k] = s_tdata[(k+2)*LANE_W +: LANE_W];
        entry_pl.work  = build_init(key_reg, in_nonce, in_ctr);
        entry_pl.count = (in_count > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : in_count;
        entry_pl.rounds = (rounds_reg > RC_W'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS)
                                                           : RND_W'(rounds_reg);
        entry_pl.phase = '0;
    end

    assign link_pl[0]    = entry_pl;
    assign link_valid[0] = s_tvalid;
    assign s_tready      = link_ready[0];

    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_cell
        salsa_step_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_pl     (link_pl[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_pl    (link_pl[i+1])
        );
    end

    salsa_out_cell u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .in_valid  (link_valid[NUM_STEPS]),
        .in_ready  (link_ready[NUM_STEPS]),
        .in_pl     (link_pl[NUM_STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {{(M_TDATA_W - CNT_LO - COUNT_W){1'b0}}, res.count, res.cipher};

    `ASSERT_IMPLIES(a_count_range, m_tvalid, m_tdata[CNT_LO +: COUNT_W] <= COUNT_W'(MAX_BYTES), "valid_bytes above block size")
    `ASSERT_IMPLIES(a_zero_count, m_tvalid && (m_tdata[CNT_LO +: COUNT_W] == '0), m_tdata[CNT_LO-1:0] == '0, "bytes past a zero count not cleared")

endmodule
